// ===== rtl/rpe_pkg.sv =====
// ----------------------------------------------------------------------------
// rpe_pkg: shared types and constants for the RLS parameter estimator
// Command and status bundles between controller and datapath, step and phase
// codes, configuration register indexes and Q-format saturation.
// ----------------------------------------------------------------------------
package rpe_pkg;

    // Index fields in the command bundle cover up to 32 parameters
    localparam int IDX_W  = 5;
    localparam int NCNT_W = 6;

    // Configuration register indexes
    localparam logic [1:0] CFG_LAMBDA    = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_PINIT     = 2'd2;
    localparam logic [1:0] CFG_NPARAMS   = 2'd3;

    // Datapath step codes
    localparam logic [3:0] STEP_NONE    = 4'd0;
    localparam logic [3:0] STEP_RESTART = 4'd1;
    localparam logic [3:0] STEP_LOAD    = 4'd2;
    localparam logic [3:0] STEP_RD      = 4'd3;
    localparam logic [3:0] STEP_MUL     = 4'd4;
    localparam logic [3:0] STEP_ACC     = 4'd5;
    localparam logic [3:0] STEP_CHECK   = 4'd6;
    localparam logic [3:0] STEP_DIVGO   = 4'd7;
    localparam logic [3:0] STEP_DIVEND  = 4'd8;
    localparam logic [3:0] STEP_FIN     = 4'd9;

    // Update phases
    localparam logic [2:0] PH_PRED  = 3'd0;
    localparam logic [2:0] PH_PPHI  = 3'd1;
    localparam logic [2:0] PH_DEN   = 3'd2;
    localparam logic [2:0] PH_GAIN  = 3'd3;
    localparam logic [2:0] PH_ROW   = 3'd4;
    localparam logic [2:0] PH_THETA = 3'd5;
    localparam logic [2:0] PH_PUPD  = 3'd6;

    typedef struct packed {
        logic [3:0]       step;
        logic [2:0]       phase;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic             b_first;
        logic             b_last;
    } t_cmd;

    typedef struct packed {
        logic              singular;
        logic              div_done;
        logic [NCNT_W-1:0] n;
    } t_stat;

    // Saturate a wide signed value to 32 bits signed
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Magnitude of a 32-bit signed value as unsigned
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? (32'd0 - v) : v;
        return r;
    endfunction

endpackage

// ===== rtl/rpe_div.sv =====
// ----------------------------------------------------------------------------
// rpe_div: iterative unsigned divider
// Restoring division of a 64-bit dividend by a 32-bit divisor, one quotient
// bit per cycle; done is registered and high for a single cycle with the last bit.
// ----------------------------------------------------------------------------
module rpe_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quotient
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_rem, n_rem;
    logic [63:0] r_quo, n_quo;
    logic [31:0] r_dvs, n_dvs;
    logic [32:0] rem_sh;
    logic        fits;

    // Shift one dividend bit into the remainder and try to subtract
    always_comb begin
        rem_sh = {r_rem, r_quo[63]};
        fits   = rem_sh >= {1'b0, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd0;
            n_rem  = 32'd0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = fits ? 32'(rem_sh - {1'b0, r_dvs}) : rem_sh[31:0];
            n_quo = {r_quo[62:0], fits};
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/rpe_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpe_ctrl: update sequencer
// Walks the phases of one update (predict, P*phi, denominator, gains, row,
// theta, covariance) over element indexes and drives the readout.
// ----------------------------------------------------------------------------
module rpe_ctrl
    import rpe_pkg::*;
#(
    parameter int MAX_PARAMS = 8
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_valid,
    input  logic  i_s_last,
    input  logic  i_s_restart,
    output logic  o_s_ready,
    input  logic  i_m_ready,
    output logic  o_m_valid,
    output logic  o_m_last,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int CW = $clog2(MAX_PARAMS + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RD      = 4'd1;
    localparam logic [3:0] S_MUL     = 4'd2;
    localparam logic [3:0] S_ACC     = 4'd3;
    localparam logic [3:0] S_CHECK   = 4'd4;
    localparam logic [3:0] S_DIVGO   = 4'd5;
    localparam logic [3:0] S_DIVWAIT = 4'd6;
    localparam logic [3:0] S_DIVEND  = 4'd7;
    localparam logic [3:0] S_FIN     = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    logic [3:0]    r_state, n_state;
    logic [2:0]    r_phase, n_phase;
    logic [IW-1:0] r_a, n_a;
    logic [IW-1:0] r_b, n_b;
    logic [CW-1:0] r_n, n_n;
    logic          b_last, a_last, multi_row, do_adv;
    logic [3:0]    step;

    assign b_last    = (CW'(r_b) + CW'(1)) == r_n;
    assign multi_row = (r_phase == PH_PPHI) || (r_phase == PH_ROW) || (r_phase == PH_PUPD);
    assign a_last    = !multi_row || ((CW'(r_a) + CW'(1)) == r_n);

    // Sequence states and step through element indexes
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_a     = r_a;
        n_b     = r_b;
        n_n     = r_n;
        step    = STEP_NONE;
        do_adv  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    step = i_s_restart ? STEP_RESTART : STEP_LOAD;
                    if (!i_s_restart && i_s_last) begin
                        n_n     = i_stat.n[CW-1:0];
                        n_phase = PH_PRED;
                        n_a     = '0;
                        n_b     = '0;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                step    = STEP_RD;
                n_state = S_MUL;
            end
            S_MUL: begin
                step    = STEP_MUL;
                n_state = S_ACC;
            end
            S_ACC: begin
                step = STEP_ACC;
                if (r_phase == PH_PUPD) begin
                    n_state = S_DIVGO;
                end else begin
                    do_adv = 1'b1;
                end
            end
            S_CHECK: begin
                step = STEP_CHECK;
                if (i_stat.singular) begin
                    n_state = S_FIN;
                end else begin
                    n_phase = PH_GAIN;
                    n_a     = '0;
                    n_b     = '0;
                    n_state = S_DIVGO;
                end
            end
            S_DIVGO: begin
                step    = STEP_DIVGO;
                n_state = S_DIVWAIT;
            end
            S_DIVWAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_DIVEND;
                end
            end
            S_DIVEND: begin
                step   = STEP_DIVEND;
                do_adv = 1'b1;
            end
            S_FIN: begin
                step    = STEP_FIN;
                n_b     = '0;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_m_ready) begin
                    if (b_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_b = r_b + IW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Advance inner index, then outer index, then phase
        if (do_adv) begin
            n_state = (r_phase == PH_GAIN) ? S_DIVGO : S_RD;
            if (!b_last) begin
                n_b = r_b + IW'(1);
            end else begin
                n_b = '0;
                if (!a_last) begin
                    n_a = r_a + IW'(1);
                end else begin
                    n_a = '0;
                    unique case (r_phase)
                        PH_PRED:  n_phase = PH_PPHI;
                        PH_PPHI:  n_phase = PH_DEN;
                        PH_DEN:   n_state = S_CHECK;
                        PH_GAIN:  begin
                            n_phase = PH_ROW;
                            n_state = S_RD;
                        end
                        PH_ROW:   n_phase = PH_THETA;
                        PH_THETA: n_phase = PH_PUPD;
                        default:  n_state = S_FIN;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_PRED;
            r_a     <= '0;
            r_b     <= '0;
            r_n     <= CW'(1);
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_a     <= n_a;
            r_b     <= n_b;
            r_n     <= n_n;
        end
    end

    assign o_s_ready     = r_state == S_IDLE;
    assign o_m_valid     = r_state == S_OUT;
    assign o_m_last      = b_last;
    assign o_cmd.step    = step;
    assign o_cmd.phase   = r_phase;
    assign o_cmd.a       = IDX_W'(r_a);
    assign o_cmd.b       = IDX_W'(r_b);
    assign o_cmd.b_first = r_b == '0;
    assign o_cmd.b_last  = b_last;

endmodule

// ===== rtl/rpe_dp.sv =====
// ----------------------------------------------------------------------------
// rpe_dp: estimator datapath
// Holds configuration, theta, regressor, covariance memory and the working
// vectors; one multiplier, one accumulator and the shared divider.
// ----------------------------------------------------------------------------
module rpe_dp
    import rpe_pkg::*;
#(
    parameter int MAX_PARAMS = 8,
    parameter int FRAC_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic signed [31:0] i_phi,
    input  logic signed [31:0] i_y,
    input  logic               i_last,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    output logic               o_status,
    output logic [31:0]        o_err,
    output logic [2:0]         o_idx,
    output logic [31:0]        o_theta,
    output logic [31:0]        o_count
);

    localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int CW = $clog2(MAX_PARAMS + 1);
    localparam int NE = MAX_PARAMS * MAX_PARAMS;
    localparam int AW = (NE > 1) ? $clog2(NE) : 1;

    // Configuration
    logic [16:0] r_lambda;
    logic [30:0] r_thr;
    logic [30:0] r_pinit_cfg;
    logic [3:0]  r_nparams;

    // Control state
    logic [30:0]        r_pinit;
    logic [CW-1:0]      r_el_cnt;
    logic [31:0]        r_count;
    logic [NE-1:0]      r_pvalid;
    logic signed [31:0] r_theta [MAX_PARAMS];
    logic signed [31:0] r_phi   [MAX_PARAMS];
    logic               r_status;

    // Working values
    logic signed [31:0] r_pphi [MAX_PARAMS];
    logic signed [31:0] r_gain [MAX_PARAMS];
    logic signed [31:0] r_row  [MAX_PARAMS];
    logic signed [31:0] r_y, r_err, r_denom, r_t;
    logic signed [63:0] r_acc, r_prod;
    logic signed [31:0] r_pdata;
    logic               r_pval, r_pdiag, r_divneg;
    logic signed [31:0] mem [NE];

    logic [IW-1:0]      ai, bi;
    logic [CW-1:0]      n_act;
    logic [16:0]        lam;
    logic [63:0]        lam_w;
    logic signed [63:0] base, q, acc_nx;
    logic signed [31:0] pe, op_a, op_b, qsat;
    logic [AW-1:0]      addr;
    logic [31:0]        dmag;
    logic               singular, div_start, div_done;
    logic [63:0]        dividend, quo;
    logic [31:0]        divisor;

    assign ai = i_cmd.a[IW-1:0];
    assign bi = i_cmd.b[IW-1:0];

    // Clamp parameter count and lambda
    always_comb begin
        if (r_nparams == 4'd0) begin
            n_act = CW'(1);
        end else if (int'(r_nparams) > MAX_PARAMS) begin
            n_act = CW'(MAX_PARAMS);
        end else begin
            n_act = CW'(r_nparams);
        end
        if (r_lambda == 17'd0) begin
            lam = 17'd1;
        end else if (r_lambda > 17'd65536) begin
            lam = 17'd65536;
        end else begin
            lam = r_lambda;
        end
        lam_w = ({47'd0, lam} << FRAC_BITS) >> 16;
    end

    // Covariance address and effective entry value
    assign addr = (i_cmd.phase == PH_ROW) ? AW'(int'(bi) * MAX_PARAMS + int'(ai))
                                          : AW'(int'(ai) * MAX_PARAMS + int'(bi));
    assign pe   = r_pval ? r_pdata : (r_pdiag ? signed'({1'b0, r_pinit}) : 32'sd0);

    // Select multiplier operands by phase
    always_comb begin
        op_a = r_phi[bi];
        op_b = r_phi[bi];
        unique case (i_cmd.phase)
            PH_PRED:  op_a = r_theta[bi];
            PH_PPHI:  op_a = pe;
            PH_DEN:   op_b = r_pphi[bi];
            PH_ROW:   op_b = pe;
            PH_THETA: begin
                op_a = r_gain[bi];
                op_b = r_err;
            end
            PH_PUPD:  begin
                op_a = r_gain[ai];
                op_b = r_row[bi];
            end
            default:  op_a = r_phi[bi];
        endcase
    end

    assign q      = r_prod >>> FRAC_BITS;
    assign base   = (i_cmd.phase == PH_DEN) ? signed'(lam_w) : 64'sd0;
    assign acc_nx = (i_cmd.b_first ? base : r_acc) + q;

    // Singular denominator test
    assign dmag     = mag32(r_denom);
    assign singular = (r_denom == 32'sd0) || (dmag < {1'b0, r_thr});

    // Divider operands
    assign div_start = i_cmd.step == STEP_DIVGO;
    always_comb begin
        if (i_cmd.phase == PH_GAIN) begin
            dividend = {32'd0, mag32(r_pphi[bi])} << FRAC_BITS;
            divisor  = dmag;
        end else begin
            dividend = {32'd0, mag32(r_t)} << 16;
            divisor  = {15'd0, lam};
        end
    end

    rpe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    // Saturate the signed quotient
    always_comb begin
        if (r_divneg) begin
            qsat = (quo > 64'd2147483648) ? 32'sh80000000 : signed'(32'd0 - quo[31:0]);
        end else begin
            qsat = (quo > 64'd2147483647) ? 32'sh7FFFFFFF : signed'(quo[31:0]);
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lambda    <= 17'd64880;
            r_thr       <= 31'd1;
            r_pinit_cfg <= 31'd6553600;
            r_nparams   <= 4'd8;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LAMBDA:    r_lambda    <= i_cfg_data[16:0];
                CFG_THRESHOLD: r_thr       <= i_cfg_data[30:0];
                CFG_PINIT:     r_pinit_cfg <= i_cfg_data[30:0];
                CFG_NPARAMS:   r_nparams   <= i_cfg_data[3:0];
                default:       r_nparams   <= r_nparams;
            endcase
        end
    end

    // Estimator state: theta, regressor, counters, valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pinit  <= 31'd6553600;
            r_el_cnt <= '0;
            r_count  <= 32'd0;
            r_pvalid <= '0;
            r_status <= 1'b0;
            for (int k = 0; k < MAX_PARAMS; k++) begin
                r_theta[k] <= 32'sd0;
                r_phi[k]   <= 32'sd0;
            end
        end else begin
            unique case (i_cmd.step)
                STEP_RESTART: begin
                    r_pinit  <= r_pinit_cfg;
                    r_el_cnt <= '0;
                    r_count  <= 32'd0;
                    r_pvalid <= '0;
                    for (int k = 0; k < MAX_PARAMS; k++) begin
                        r_theta[k] <= 32'sd0;
                        r_phi[k]   <= 32'sd0;
                    end
                end
                STEP_LOAD: begin
                    if (r_el_cnt < n_act) begin
                        r_phi[r_el_cnt[IW-1:0]] <= i_phi;
                        r_el_cnt                <= r_el_cnt + CW'(1);
                    end
                end
                STEP_ACC: begin
                    if (i_cmd.phase == PH_THETA) begin
                        r_theta[bi] <= sat32(64'(r_theta[bi]) + q);
                    end
                end
                STEP_CHECK: begin
                    r_status <= singular;
                end
                STEP_DIVEND: begin
                    if (i_cmd.phase == PH_PUPD) begin
                        r_pvalid[addr] <= 1'b1;
                    end
                end
                STEP_FIN: begin
                    r_el_cnt <= '0;
                    if (!r_status) begin
                        r_count <= r_count + 32'd1;
                    end
                    for (int k = 0; k < MAX_PARAMS; k++) begin
                        r_phi[k] <= 32'sd0;
                    end
                end
                default: begin
                    r_el_cnt <= r_el_cnt;
                end
            endcase
        end
    end

    // Working values: multiply, accumulate, divide results
    always_ff @(posedge i_clk) begin
        if (i_cmd.step == STEP_LOAD && i_last) begin
            r_y <= i_y;
        end
        if (i_cmd.step == STEP_MUL) begin
            r_prod <= op_a * op_b;
        end
        if (i_cmd.step == STEP_ACC) begin
            r_acc <= acc_nx;
            unique case (i_cmd.phase)
                PH_PRED: begin
                    if (i_cmd.b_last) begin
                        r_err <= sat32(64'(r_y) - 64'(sat32(acc_nx)));
                    end
                end
                PH_PPHI: begin
                    if (i_cmd.b_last) begin
                        r_pphi[ai] <= sat32(acc_nx);
                    end
                end
                PH_DEN: begin
                    if (i_cmd.b_last) begin
                        r_denom <= sat32(acc_nx);
                    end
                end
                PH_ROW: begin
                    if (i_cmd.b_last) begin
                        r_row[ai] <= sat32(acc_nx);
                    end
                end
                PH_PUPD: begin
                    r_t <= sat32(64'(pe) - q);
                end
                default: begin
                    r_t <= r_t;
                end
            endcase
        end
        if (div_start) begin
            r_divneg <= (i_cmd.phase == PH_GAIN) ? (r_pphi[bi][31] ^ r_denom[31]) : r_t[31];
        end
        if (i_cmd.step == STEP_DIVEND && i_cmd.phase == PH_GAIN) begin
            r_gain[bi] <= qsat;
        end
    end

    // Covariance memory: one port, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.step == STEP_DIVEND && i_cmd.phase == PH_PUPD) begin
            mem[addr] <= qsat;
        end
        if (i_cmd.step == STEP_RD) begin
            r_pdata <= mem[addr];
            r_pval  <= r_pvalid[addr];
            r_pdiag <= ai == bi;
        end
    end

    assign o_stat.singular = singular;
    assign o_stat.div_done = div_done;
    assign o_stat.n        = NCNT_W'(n_act);
    assign o_status        = r_status;
    assign o_err           = r_err;
    assign o_idx           = 3'(bi);
    assign o_theta         = r_theta[bi];
    assign o_count         = r_count;

endmodule

// ===== rtl/rls_parameter_estimator.sv =====
// ----------------------------------------------------------------------------
// rls_parameter_estimator: recursive least squares with forgetting factor
// Usage:
//   Input stream: one transaction per regressor element (tdata low word),
//   tlast marks the final element and carries the measurement (tdata high
//   word); tuser set restarts the estimate (theta zero, P = p_init * I).
//   Elements are accepted back to back while the block is idle.
//   After the final element the update runs on one multiplier and a bit-serial
//   divider: multiply-accumulate for each phase, one division per gain and one
//   per covariance entry; a singular denominator ends the update early.
//   Output stream: n transactions, one per theta value, tlast on the final
//   one; tuser carries status (1 = singular, nothing changed). A stalled
//   receiver holds the readout and the input stays not ready until the last
//   result is taken.
//   Reset loads the default configuration and the restart state at once.
//   Configuration writes complete every cycle; the user makes them while idle (not enforced).
// ----------------------------------------------------------------------------
module rls_parameter_estimator
    import rpe_pkg::*;
#(
    parameter int MAX_PARAMS = 8,
    parameter int FRAC_BITS  = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    // Input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // phi_value[31:0], y_meas[63:32]
    input  logic         s_axis_tuser,   // restart
    input  logic         s_axis_tlast,   // last_element
    // Result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // prediction_error[31:0],
                                         // param_index[34:32],
                                         // theta_value[66:35],
                                         // update_count[98:67], zero[103:99]
    output logic         m_axis_tuser,   // status
    output logic         m_axis_tlast    // last
);

    t_cmd        cmd;
    t_stat       stat;
    logic [31:0] err, theta, count;
    logic [2:0]  idx;

    assign o_cfg_ready = 1'b1;

    rpe_ctrl #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (s_axis_tvalid),
        .i_s_last    (s_axis_tlast),
        .i_s_restart (s_axis_tuser),
        .o_s_ready   (s_axis_tready),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_m_last    (m_axis_tlast),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rpe_dp #(
        .MAX_PARAMS (MAX_PARAMS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_phi       (s_axis_tdata[31:0]),
        .i_y         (s_axis_tdata[63:32]),
        .i_last      (s_axis_tlast),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_status    (m_axis_tuser),
        .o_err       (err),
        .o_idx       (idx),
        .o_theta     (theta),
        .o_count     (count)
    );

    // Pack result fields
    assign m_axis_tdata = {5'd0, count, theta, idx, err};

endmodule

// ===== bench/rls_parameter_estimator_tb.sv =====
// ----------------------------------------------------------------------------
// rls_parameter_estimator_tb: self-checking bench for the RLS estimator
// Streams regressor frames, restarts and odd-length frames into the block
// under several configurations. A scoreboard mirrors the Q16.16 update and
// checks every theta readout field by field, with random bursts, receiver
// stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module rls_parameter_estimator_tb;
    import rpe_pkg::*;

    localparam int  NMAX      = 8;
    localparam int  FRAC      = 16;
    localparam int  LIMIT     = 8000000;
    localparam int  HOLD_LEN  = 6000;

    typedef struct {
        bit        status;
        bit [31:0] err;
        bit [2:0]  idx;
        bit [31:0] theta;
        bit [31:0] count;
        bit        last;
    } estimate_t;

    // Mirror of the estimator state and expected readout queue
    class rls_scoreboard;
        longint    lam_reg, thr_reg, pinit_reg, nreg;
        longint    theta[NMAX];
        longint    cov[NMAX*NMAX];
        longint    phi_buf[NMAX];
        int        elem_cnt;
        bit [31:0] updates;
        estimate_t pending[$];
        int        fails;

        function new();
            lam_reg   = 64880;
            thr_reg   = 1;
            pinit_reg = 6553600;
            nreg      = 8;
            fails     = 0;
            restart_state();
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // Product rounded toward minus infinity
        function longint qmul(longint a, longint b);
            longint p;
            p = a * b;
            return p >>> FRAC;
        endfunction

        function void restart_state();
            for (int i = 0; i < NMAX; i++) begin
                theta[i]   = 0;
                phi_buf[i] = 0;
                for (int j = 0; j < NMAX; j++)
                    cov[i*NMAX+j] = (i == j) ? clip32(pinit_reg) : 0;
            end
            elem_cnt = 0;
            updates  = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] v);
            case (idx)
                CFG_LAMBDA:    lam_reg   = v[16:0];
                CFG_THRESHOLD: thr_reg   = v[30:0];
                CFG_PINIT:     pinit_reg = v[30:0];
                CFG_NPARAMS:   nreg      = v[3:0];
                default: ;
            endcase
        endfunction

        // Note an accepted input item and queue the readout it causes
        function void note_input(bit rs, bit [31:0] phi, bit [31:0] y, bit lst);
            int        n;
            longint    lam, lam_q, acc, err, den, mag;
            longint    pphi[NMAX], gain[NMAX], row[NMAX];
            bit        sing;
            longint    t;
            estimate_t r;
            n = (nreg < 1) ? 1 : (nreg > NMAX) ? NMAX : int'(nreg);
            if (rs) begin
                restart_state();
                return;
            end
            if (elem_cnt < n) begin
                phi_buf[elem_cnt] = longint'($signed(phi));
                elem_cnt++;
            end
            if (!lst) return;

            lam   = (lam_reg < 1) ? 1 : (lam_reg > 65536) ? 65536 : lam_reg;
            lam_q = (lam * (64'sd1 << FRAC)) / 65536;
            acc = 0;
            for (int i = 0; i < n; i++) acc += qmul(theta[i], phi_buf[i]);
            err = clip32(longint'($signed(y)) - clip32(acc));
            for (int i = 0; i < n; i++) begin
                acc = 0;
                for (int j = 0; j < n; j++) acc += qmul(cov[i*NMAX+j], phi_buf[j]);
                pphi[i] = clip32(acc);
            end
            acc = lam_q;
            for (int i = 0; i < n; i++) acc += qmul(phi_buf[i], pphi[i]);
            den  = clip32(acc);
            mag  = (den < 0) ? -den : den;
            sing = (den == 0) || (mag < thr_reg);
            if (!sing) begin
                for (int i = 0; i < n; i++)
                    gain[i] = clip32((pphi[i] * (64'sd1 << FRAC)) / den);
                for (int j = 0; j < n; j++) begin
                    acc = 0;
                    for (int i = 0; i < n; i++) acc += qmul(phi_buf[i], cov[i*NMAX+j]);
                    row[j] = clip32(acc);
                end
                for (int i = 0; i < n; i++)
                    theta[i] = clip32(theta[i] + qmul(gain[i], err));
                for (int i = 0; i < n; i++) begin
                    for (int j = 0; j < n; j++) begin
                        t = clip32(cov[i*NMAX+j] - qmul(gain[i], row[j]));
                        cov[i*NMAX+j] = clip32((t * 65536) / lam);
                    end
                end
                updates++;
            end
            for (int i = 0; i < NMAX; i++) phi_buf[i] = 0;
            elem_cnt = 0;
            for (int i = 0; i < n; i++) begin
                r.status = sing;
                r.err    = err[31:0];
                r.idx    = i[2:0];
                r.theta  = theta[i][31:0];
                r.count  = updates;
                r.last   = (i == n - 1);
                pending.push_back(r);
            end
        endfunction

        // Compare one readout transaction with the oldest expectation
        function void check_result(estimate_t got);
            estimate_t e;
            if (pending.size() == 0) begin
                $error("unexpected result transaction, index %0d", got.idx);
                fails++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, got.status);
                fails++;
            end
            if (got.err !== e.err) begin
                $error("prediction_error: expected %0d, actual %0d",
                       $signed(e.err), $signed(got.err));
                fails++;
            end
            if (got.idx !== e.idx) begin
                $error("param_index: expected %0d, actual %0d", e.idx, got.idx);
                fails++;
            end
            if (got.theta !== e.theta) begin
                $error("theta_value: expected %0d, actual %0d",
                       $signed(e.theta), $signed(got.theta));
                fails++;
            end
            if (got.count !== e.count) begin
                $error("update_count: expected %0d, actual %0d", e.count, got.count);
                fails++;
            end
            if (got.last !== e.last) begin
                $error("last: expected %0d, actual %0d", e.last, got.last);
                fails++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;
    logic         s_axis_tuser;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    logic         long_hold;
    int           cycles;
    int           burst_left;
    rls_scoreboard sb;

    rls_parameter_estimator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Watchdog
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: alternate between always ready and random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n || long_hold) begin
            m_axis_tready <= 1'b0;
        end else if (cycles[9]) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Release the long hold-off after a fixed stretch
    initial begin
        wait (long_hold === 1'b1);
        repeat (HOLD_LEN) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    // Check every readout transaction
    always @(posedge i_clk) begin
        estimate_t got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.err    = m_axis_tdata[31:0];
            got.idx    = m_axis_tdata[34:32];
            got.theta  = m_axis_tdata[66:35];
            got.count  = m_axis_tdata[98:67];
            got.status = m_axis_tuser;
            got.last   = m_axis_tlast;
            sb.check_result(got);
        end
    end

    // Write one register; the caller drops valid after the last write
    task automatic write_cfg(logic [1:0] idx, logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, v);
    endtask

    // Offer one item, with bursts separated by random gaps
    task automatic send_item(bit rs, logic [31:0] phi, logic [31:0] y, bit lst);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, phi};
        s_axis_tuser  <= rs;
        s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(rs, phi, y, lst);
    endtask

    function automatic logic [31:0] rand_q();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $urandom_range(0, 524288) - 262144;
    endfunction

    // Hold until every expected readout has come, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // Random frames: mostly full length, some short, long or broken by restarts
    task automatic random_frames(int items, int n);
        int sent, len, pick;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                send_item(1'b1, $urandom, $urandom, $urandom_range(0, 1));
                sent++;
            end else begin
                len = (pick < 16) ? n : $urandom_range(1, n + 2);
                for (int k = 0; k < len; k++) begin
                    send_item(1'b0, rand_q(), rand_q(), k == len - 1);
                    sent++;
                end
            end
        end
    endtask

    task automatic run_phase(logic [31:0] lam, logic [31:0] thr, logic [31:0] pinit,
                             logic [31:0] n, int items, bit hold);
        write_cfg(CFG_LAMBDA, lam);
        write_cfg(CFG_THRESHOLD, thr);
        write_cfg(CFG_PINIT, pinit);
        write_cfg(CFG_NPARAMS, n);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        send_item(1'b1, 32'h0, 32'h0, 1'b0);
        if (hold) long_hold <= 1'b1;
        random_frames(items, (n < 1) ? 1 : (n > NMAX) ? NMAX : int'(n));
        drain();
    endtask

    initial begin
        sb            = new();
        burst_left    = 0;
        long_hold     = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_LAMBDA;
        i_cfg_data    = 32'h0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 64'h0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset configuration
        send_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        for (int k = 0; k < 8; k++)
            send_item(1'b0, 32'h0001_0000, 32'h7FFF_FFFF, k == 7);
        // Too many elements with extreme values
        for (int k = 0; k < 10; k++)
            send_item(1'b0, k[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, 32'h8000_0000, k == 9);
        // Too few elements
        send_item(1'b0, 32'hFFFF_0000, 32'h0000_0000, 1'b0);
        send_item(1'b0, 32'h0000_8000, 32'h0003_0000, 1'b1);
        send_item(1'b1, 32'h0, 32'h0, 1'b0);
        // Zero regressor: denominator is lambda alone
        send_item(1'b0, 32'h0, 32'h0002_0000, 1'b1);
        drain();

        run_phase(32'd0,      32'd0,          32'h7FFF_FFFF, 32'd2,  50, 1'b0);
        run_phase(32'h1_FFFF, 32'd1,          32'd65536,     32'd3,  70, 1'b1);
        run_phase(32'd65536,  32'h7FFF_FFFF,  32'd1,         32'd1,  25, 1'b0);
        run_phase(32'd60000,  32'd100,        32'd655360,    32'd4,  80, 1'b0);
        run_phase(32'd64880,  32'd16,         32'd6553600,   32'd0,  40, 1'b0);
        run_phase(32'd65000,  32'd1,          32'd100000,    32'd15, 50, 1'b0);
        run_phase(32'd65536,  32'd1,          32'd65536,     32'd5,  60, 1'b0);

        if (sb.fails == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
